// ----- hdl/rast_pkg.sv -----
package rast_pkg;
	localparam int unsigned SIZE = 1024;
	localparam int unsigned IDX_W = $clog2(SIZE);
	localparam int unsigned NODE_W = IDX_W + 1;
	localparam int unsigned LVL_W = $clog2(IDX_W + 2);
	localparam logic [63:0] EMPTY_MIN = 64'd1000000000000000000;
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic        we;
		node_t       addr;
		logic [63:0] sum;
		logic [63:0] mn;
		logic [63:0] pend;
	} mem_wr_t;

	function automatic logic [63:0] smin(input logic [63:0] a, input logic [63:0] b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction
endpackage

// ----- hdl/rast_node_ram.sv -----
module rast_node_ram (
	input  logic             clk,
	input  rast_pkg::node_t  rd_addr,
	output logic [63:0]      rd_sum,
	output logic [63:0]      rd_min,
	output logic [63:0]      rd_pend,
	input  rast_pkg::mem_wr_t wr
);
	import rast_pkg::*;
	logic [191:0] mem [2*SIZE];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= {wr.pend, wr.mn, wr.sum};
		end
		{rd_pend, rd_min, rd_sum} <= mem[rd_addr];
	end
endmodule

// ----- hdl/range_add_sum_min_tree.sv -----
// A query raises m_tvalid once ST_OUT has registered its result; an empty range goes
// from ST_IDLE straight to ST_OUT.
// One item at a time; a query holds the block until its result is taken on m_tready,
// an add until its write back ends, bound by the single node memory port (one read per cycle).
// Reset: after arst_n falls, a clearing pass writes zero to all 2 * SIZE nodes,
// one per cycle, during which s_tready stays low.
module range_add_sum_min_tree (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[0], first_index[10:1], last_index[20:11], add_value[52:21], zero fill
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// range_sum[63:0], range_min[127:64]
	output logic [127:0] m_tdata
);
	import rast_pkg::*;

	typedef enum logic [9:0] {
		ST_CLR   = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_PRD   = 10'b0000000100,
		ST_PCH   = 10'b0000001000,
		ST_WALK  = 10'b0000010000,
		ST_WRD   = 10'b0000100000,
		ST_RBA   = 10'b0001000000,
		ST_RBB   = 10'b0010000000,
		ST_RBP   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} st_t;

	st_t          st_q;
	node_t        clr_q;
	logic         op_q;
	logic [IDX_W:0] first_q, last_q;
	logic [63:0]  v_q;
	logic         pass_q;        // 0 first path, 1 last path
	logic [LVL_W-1:0] lvl_q;
	logic [1:0]   sub_q;
	logic [63:0]  pp_q;
	logic [NODE_W:0] l_q, r_q;
	logic [LVL_W-1:0] len_sh_q;  // node span as a power of two
	logic [1:0]   wph_q;         // walk phase: 0 left edge, 2 right edge
	logic [63:0]  acc_sum_q, acc_min_q;
	logic [63:0]  ca_sum_q, ca_min_q;
	node_t        p_q;
	logic [63:0]  res_sum_q, res_min_q;
	logic         out_v_q;

	node_t        rd_addr;
	logic [63:0]  rd_sum, rd_min, rd_pend;
	mem_wr_t      wr;

	rast_node_ram u_ram (
		.clk(clk), .rd_addr(rd_addr), .rd_sum(rd_sum), .rd_min(rd_min),
		.rd_pend(rd_pend), .wr(wr)
	);

	logic [IDX_W:0] s_last_c;
	logic [NODE_W-1:0] leaf_c;
	node_t        pnode_c;
	node_t        child_c;
	logic [NODE_W:0] cur_c;

	always_comb begin
		s_last_c = {1'b0, s_tdata[20:11]};
		if (s_last_c > (IDX_W+1)'(SIZE - 1)) s_last_c = (IDX_W+1)'(SIZE - 1);
		leaf_c = pass_q ? NODE_W'(last_q) + NODE_W'(SIZE) : NODE_W'(first_q) + NODE_W'(SIZE);
		pnode_c = node_t'(leaf_c >> lvl_q);
		child_c = {pnode_c[NODE_W-2:0], sub_q[0]};
		cur_c = (wph_q[1]) ? r_q - 1'b1 : l_q;
	end

	always_comb begin
		rd_addr = '0;
		wr = '0;
		case (st_q)
			ST_CLR: begin
				wr.we = 1'b1;
				wr.addr = clr_q;
			end
			ST_PRD: rd_addr = pnode_c;
			ST_PCH: rd_addr = child_c;
			ST_WALK: rd_addr = node_t'(cur_c);
			ST_RBA: rd_addr = {p_q[NODE_W-2:0], 1'b0};
			ST_RBB: rd_addr = {p_q[NODE_W-2:0], 1'b1};
			ST_RBP: rd_addr = p_q;
			default: rd_addr = '0;
		endcase
		// parent keeps sum and min, its pending add moves to the children
		if (st_q == ST_PCH && sub_q == 2'd0 && rd_pend != '0) begin
			wr.we = 1'b1;
			wr.addr = pnode_c;
			wr.sum = rd_sum;
			wr.mn = rd_min;
			wr.pend = '0;
		end
		if (st_q == ST_PCH && (sub_q == 2'd1 || sub_q == 2'd2)) begin
			wr.we = 1'b1;
			wr.addr = {pnode_c[NODE_W-2:0], sub_q[1]};
			wr.sum = rd_sum + (pp_q << (lvl_q - 1'b1));
			wr.mn = rd_min + pp_q;
			wr.pend = (lvl_q > LVL_W'(1)) ? rd_pend + pp_q : rd_pend;
		end
		if (st_q == ST_WRD && op_q == OP_ADD) begin
			wr.we = 1'b1;
			wr.addr = node_t'(cur_c);
			wr.sum = rd_sum + (v_q << len_sh_q);
			wr.mn = rd_min + v_q;
			wr.pend = (cur_c < (NODE_W+1)'(SIZE)) ? rd_pend + v_q : rd_pend;
		end
		if (st_q == ST_RBP && sub_q == 2'd1) begin
			wr.we = 1'b1;
			wr.addr = p_q;
			wr.sum = acc_sum_q + ca_sum_q + (rd_pend << len_sh_q);
			wr.mn = smin(acc_min_q, ca_min_q) + rd_pend;
			wr.pend = rd_pend;
		end
	end

	assign s_tready = (st_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {res_min_q, res_sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			pass_q <= 1'b0;
			lvl_q <= '0;
			sub_q <= '0;
			wph_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == node_t'(2*SIZE - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q <= s_tdata[0];
						first_q <= {1'b0, s_tdata[10:1]};
						last_q <= s_last_c;
						v_q <= {{32{s_tdata[52]}}, s_tdata[52:21]};
						acc_sum_q <= '0;
						acc_min_q <= EMPTY_MIN;
						pass_q <= 1'b0;
						lvl_q <= LVL_W'(IDX_W + 1);
						if ({1'b0, s_tdata[10:1]} > s_last_c ||
							(s_tdata[0] == OP_ADD && s_tdata[52:21] == '0)) begin
							if (s_tdata[0] == OP_QUERY) st_q <= ST_OUT;
						end else begin
							st_q <= ST_PRD;
						end
					end
				end
				ST_PRD: begin
					if (lvl_q == '0) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							lvl_q <= LVL_W'(IDX_W + 1);
						end else begin
							st_q <= ST_WALK;
							l_q <= (NODE_W+1)'(first_q) + (NODE_W+1)'(SIZE);
							r_q <= (NODE_W+1)'(last_q) + (NODE_W+1)'(SIZE + 1);
							len_sh_q <= '0;
							wph_q <= 2'd0;
						end
					end else if (pnode_c == '0 || lvl_q == LVL_W'(IDX_W + 1)) begin
						lvl_q <= lvl_q - 1'b1;
					end else begin
						st_q <= ST_PCH;
						sub_q <= 2'd0;
					end
				end
				ST_PCH: begin
					case (sub_q)
						2'd0: begin
							pp_q <= rd_pend;
							if (rd_pend == '0) begin
								st_q <= ST_PRD;
								lvl_q <= lvl_q - 1'b1;
							end else begin
								sub_q <= 2'd1;
							end
						end
						2'd1: sub_q <= 2'd2;
						2'd2: begin
							st_q <= ST_PRD;
							lvl_q <= lvl_q - 1'b1;
							sub_q <= 2'd0;
						end
						default: begin
							sub_q <= 2'd0;
						end
					endcase
				end
				ST_WALK: begin
					if (l_q >= r_q) begin
						if (op_q == OP_QUERY) begin
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_RBA;
							pass_q <= 1'b0;
							p_q <= node_t'(((NODE_W)'(first_q) + NODE_W'(SIZE)) >> 1);
							len_sh_q <= LVL_W'(1);
							sub_q <= 2'd0;
						end
					end else if (wph_q == 2'd0) begin
						if (l_q[0]) st_q <= ST_WRD;
						else wph_q <= 2'd2;
					end else begin
						if (r_q[0]) st_q <= ST_WRD;
						else begin
							wph_q <= 2'd0;
							l_q <= l_q >> 1;
							r_q <= r_q >> 1;
							len_sh_q <= len_sh_q + 1'b1;
						end
					end
				end
				ST_WRD: begin
					if (op_q == OP_QUERY) begin
						acc_sum_q <= acc_sum_q + rd_sum;
						acc_min_q <= smin(acc_min_q, rd_min);
					end
					st_q <= ST_WALK;
					if (wph_q == 2'd0) begin
						l_q <= l_q + 1'b1;
						wph_q <= 2'd2;
					end else begin
						wph_q <= 2'd0;
						l_q <= l_q >> 1;
						r_q <= (r_q - 1'b1) >> 1;
						len_sh_q <= len_sh_q + 1'b1;
					end
				end
				ST_RBA: begin
					if (p_q == '0) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							p_q <= node_t'(((NODE_W)'(last_q) + NODE_W'(SIZE)) >> 1);
							len_sh_q <= LVL_W'(1);
						end else begin
							st_q <= ST_IDLE;
						end
					end else begin
						st_q <= ST_RBB;
					end
				end
				ST_RBB: begin
					acc_sum_q <= rd_sum;
					acc_min_q <= rd_min;
					st_q <= ST_RBP;
					sub_q <= 2'd0;
				end
				ST_RBP: begin
					if (sub_q == 2'd0) begin
						ca_sum_q <= rd_sum;
						ca_min_q <= rd_min;
						sub_q <= 2'd1;
					end else begin
						st_q <= ST_RBA;
						p_q <= p_q >> 1;
						len_sh_q <= len_sh_q + 1'b1;
					end
				end
				ST_OUT: begin
					res_sum_q <= acc_sum_q;
					res_min_q <= acc_min_q;
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> m_tvalid)
		else $error("query result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> !s_tready)
		else $error("input taken during clearing pass");
endmodule
